@@ src/gwa_pkg.sv @@
// Shared constants and types for the gated window average block.
`timescale 1ns / 1ps

package gwa_pkg;

  // Ring capacity and derived widths
  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned ADDR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = SAMPLE_W + ADDR_W;
  localparam int unsigned WLEN_W     = 7;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd2;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = 16'sd20;
  localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = 16'sd255;
  localparam logic [WLEN_W-1:0]          WLEN_RESET  = 7'd8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } gwa_state_e;

endpackage

@@ src/gwa_div.sv @@
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module gwa_div
  import gwa_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUM_W-1:0]    dividend_i,
  input  logic [CNT_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic signed [SAMPLE_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W:0]    rem_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W:0]    rem_d;
  logic [SAMPLE_W-1:0] qmag;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
    qbit  = (trial >= {1'b0, dsr_q});
    rem_d = qbit ? (trial - {1'b0, dsr_q}) : trial;
  end

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitude, then shift quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      dvd_q <= dividend_i[SUM_W-1] ? (SUM_W'(0) - SUM_W'(dividend_i))
                                   : SUM_W'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SUM_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  // Restore the sign; the mean always fits the sample width
  assign qmag       = dvd_q[SAMPLE_W-1:0];
  assign quotient_o = neg_q ? $signed(SAMPLE_W'(0) - qmag) : $signed(qmag);
  assign done_o     = done_q;

endmodule

@@ src/gated_window_average.sv @@
// Top level of the range-gated moving average over a ring of recent samples.
`timescale 1ns / 1ps

// Each input word carries one signed sample. A sample strictly between
// lower_limit and upper_limit goes into a ring memory of up to WINDOW_MAX
// entries (window_len in use, oldest overwritten) and the block returns the
// mean of the held samples, truncated toward zero, with available set. A
// sample outside the limits changes nothing and returns the last mean with
// available clear. One item is worked on at a time. An accepted sample
// raises out_valid after one memory read per held sample through the
// single read port, the drain of the read pipe, the bit-serial divider
// and the load of the output register; a rejected sample goes straight
// to the output register. The next sample can be taken once the result
// is loaded, also while that result still waits in the output register.
// Writing window_len empties the ring; write configuration only while
// the block is idle.
module gated_window_average
  import gwa_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SAMPLE_W-1:0]        cfg_data_i,
  // Sample input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] average_o,
  output logic                       available_o
);

  gwa_state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] lower_q, upper_q;
  logic [WLEN_W-1:0]          wlen_q;
  logic [ADDR_W-1:0]          slot_q;
  logic [CNT_W-1:0]           held_q;
  logic signed [SAMPLE_W-1:0] last_avg_q;
  logic [CNT_W-1:0]           rd_cnt_q;
  logic                       rd_pend_q;
  logic signed [SUM_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] res_avg_q;
  logic                       res_avail_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] average_q;
  logic                       available_q;

  logic [SAMPLE_W-1:0] mem_q [WINDOW_MAX];
  logic [SAMPLE_W-1:0] rdata_q;

  logic                in_acc, cfg_acc, pass, issue, sum_done, out_load;
  logic                div_start, div_done;
  logic signed [SAMPLE_W-1:0] div_quo;
  logic [CNT_W-1:0]    eff_len;
  logic [ADDR_W-1:0]   wr_slot;
  logic [CNT_W-1:0]    slot_inc;
  logic [ADDR_W-1:0]   slot_nxt;
  logic [CNT_W-1:0]    held_nxt;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // Clamp the window length to 1 .. WINDOW_MAX
  always_comb begin
    if (wlen_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(wlen_q) > WINDOW_MAX) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = CNT_W'(wlen_q);
    end
  end

  // Range gate, slot and fill count updates
  always_comb begin
    pass     = (sample_i > lower_q) && (sample_i < upper_q);
    wr_slot  = (CNT_W'(slot_q) >= eff_len) ? '0 : slot_q;
    slot_inc = CNT_W'(wr_slot) + CNT_W'(1);
    slot_nxt = (slot_inc >= eff_len) ? '0 : slot_inc[ADDR_W-1:0];
    held_nxt = (held_q < eff_len) ? held_q + CNT_W'(1) : held_q;
    if (held_nxt > eff_len) begin
      held_nxt = eff_len;
    end
  end

  // Summing sweep: one read per held entry, read data registered for the next cycle
  assign issue    = (state_q == ST_SUM) && (rd_cnt_q < held_q);
  assign sum_done = (state_q == ST_SUM) && !issue && !rd_pend_q;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Next state and divider start
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = pass ? ST_SUM : ST_OUT;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, configuration and ring bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lower_q     <= LOWER_RESET;
      upper_q     <= UPPER_RESET;
      wlen_q      <= WLEN_RESET;
      slot_q      <= '0;
      held_q      <= '0;
      last_avg_q  <= '0;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        unique case (cfg_index_i)
          REG_LOWER_LIMIT: lower_q <= cfg_data_i;
          REG_UPPER_LIMIT: upper_q <= cfg_data_i;
          REG_WINDOW_LEN: begin
            wlen_q <= cfg_data_i[WLEN_W-1:0];
            slot_q <= '0;
            held_q <= '0;
          end
          default: ;
        endcase
      end
      if (in_acc && pass) begin
        slot_q   <= slot_nxt;
        held_q   <= held_nxt;
        rd_cnt_q <= '0;
      end
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      rd_pend_q <= issue;
      if (div_done) begin
        last_avg_q <= div_quo;
      end
      // Drop a taken word, hold a waiting one, load a fresh one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && pass) begin
      mem_q[wr_slot] <= sample_i;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_cnt_q[ADDR_W-1:0]];
    end
  end

  // Accumulate and stage the result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q       <= '0;
      res_avg_q   <= last_avg_q;
      res_avail_q <= pass;
    end else if (rd_pend_q) begin
      acc_q <= acc_q + SUM_W'($signed(rdata_q));
    end
    if (div_done) begin
      res_avg_q <= div_quo;
    end
    if (out_load) begin
      average_q   <= res_avg_q;
      available_q <= res_avail_q;
    end
  end

  gwa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (held_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign available_o = available_q;

endmodule
